@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define DRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: same-cycle consequence");

// Check a condition in the cycle after its trigger
`define DRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: next-cycle consequence");

`endif

@@ src/drs_pkg.sv @@
// ----------------------------------------------------------------------------
// drs_pkg
// Types, constants and geometry helpers of the dirty rectangle set.
// ----------------------------------------------------------------------------
package drs_pkg;

	// Depth of the pending-fragment stack and its counter widths
	localparam int FRAG_DEPTH = 32;
	localparam int FAW        = 5;
	localparam int SDW        = 6;
	localparam int REC_W      = 64;
	localparam int CRD_W      = 18;

	typedef logic signed [CRD_W-1:0] crd_t;

	localparam crd_t MAX_EDGE = 18'sd32767;

	typedef enum logic [1:0] {
		CMD_ADD  = 2'd0,
		CMD_SUB  = 2'd1,
		CMD_CLIP = 2'd2,
		CMD_DUMP = 2'd3
	} cmd_t;

	// Stored form of a rectangle
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] w;
		logic [15:0] h;
	} rec_t;

	// Working form with headroom for edge arithmetic
	typedef struct packed {
		crd_t x;
		crd_t y;
		crd_t w;
		crd_t h;
	} box_t;

	typedef enum logic [2:0] {
		ACT_SKIP  = 3'd0,
		ACT_COVER = 3'd1,
		ACT_DEL   = 3'd2,
		ACT_TRIM  = 3'd3,
		ACT_ADV   = 3'd4
	} act_t;

	typedef struct packed {
		act_t act;
		box_t p_new;
		box_t n_mod;
		box_t xr;
		logic split;
		logic keep;
	} add_res_t;

	typedef struct packed {
		rec_t       rec;
		logic [5:0] total;
		logic       ovf;
		logic       last;
	} res_item_t;

	typedef struct packed {
		logic idle;
		logic load;
	} eng_stat_t;

	function automatic box_t rec2box(rec_t r);
		box_t b;
		b.x = {{2{r.x[15]}}, r.x};
		b.y = {{2{r.y[15]}}, r.y};
		b.w = {2'b00, r.w};
		b.h = {2'b00, r.h};
		return b;
	endfunction

	function automatic rec_t box2rec(box_t b);
		rec_t r;
		r.x = b.x[15:0];
		r.y = b.y[15:0];
		r.w = b.w[15:0];
		r.h = b.h[15:0];
		return r;
	endfunction

	function automatic crd_t crd_max(crd_t a, crd_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic crd_t crd_min(crd_t a, crd_t b);
		return (a < b) ? a : b;
	endfunction

	// One step of the add walk: new rectangle n against stored entry p
	function automatic add_res_t add_eval(box_t n, crd_t nr, crd_t nb,
			box_t p, crd_t pr, crd_t pb);
		add_res_t r;
		box_t     nm;
		box_t     xr;
		logic     extra;
		logic     hspan;
		logic     vspan;
		r       = '0;
		r.act   = ACT_ADV;
		r.p_new = p;
		nm      = n;
		xr      = n;
		extra   = 1'b0;
		hspan   = (n.x <= p.x) && (nr >= pr);
		vspan   = (n.y <= p.y) && (nb >= pb);
		if (n.x >= pr || nr <= p.x || n.y >= pb || nb <= p.y) begin
			r.act = ACT_SKIP;
		end else if (n.x >= p.x && nr <= pr && n.y >= p.y && nb <= pb) begin
			r.act = ACT_COVER;
		end else if (hspan && vspan) begin
			r.act = ACT_DEL;
		end else if (hspan && n.y <= p.y && nb > p.y) begin
			r.act       = ACT_TRIM;
			r.p_new.y   = nb;
			r.p_new.h   = p.h - (nb - p.y);
		end else if (hspan && n.y < pb && nb >= pb) begin
			r.act       = ACT_TRIM;
			r.p_new.h   = p.h - (pb - n.y);
		end else if (!hspan && vspan && n.x <= p.x && nr > p.x) begin
			r.act       = ACT_TRIM;
			r.p_new.x   = nr;
			r.p_new.w   = p.w - (nr - p.x);
		end else if (!hspan && vspan && n.x < pr && nr >= pr) begin
			r.act       = ACT_TRIM;
			r.p_new.w   = p.w - (pr - n.x);
		end else begin
			// Strip above the entry
			if (n.y < p.y) begin
				extra = 1'b1;
				xr.h  = p.y - n.y;
				nm.h  = n.h - (p.y - n.y);
				nm.y  = p.y;
			end
			// Left side
			if (nm.x < p.x) begin
				if (!extra) begin
					extra = 1'b1;
					xr.x  = nm.x;
					xr.y  = nm.y;
					xr.w  = p.x - nm.x;
					xr.h  = (nb < pb) ? nm.h : pb - nm.y;
				end else begin
					nm.w    = p.x - nm.x;
					r.split = 1'b1;
				end
			end
			// Right side
			if (!r.split && nr > pr) begin
				if (!extra) begin
					extra = 1'b1;
					xr.x  = pr;
					xr.y  = nm.y;
					xr.w  = nr - pr;
					xr.h  = (nb < pb) ? nm.h : pb - nm.y;
				end else begin
					nm.w    = nr - pr;
					nm.x    = pr;
					r.split = 1'b1;
				end
			end
			// Strip below the entry
			if (!r.split && nb > pb) begin
				nm.h = nb - pb;
				nm.y = pb;
				if (!extra) begin
					r.keep = 1'b1;
				end else begin
					r.split = 1'b1;
				end
			end
		end
		r.n_mod = nm;
		r.xr    = xr;
		return r;
	endfunction

endpackage

@@ src/drs_if.sv @@
// ----------------------------------------------------------------------------
// drs channel interfaces
// Command channel and result channel of the dirty rectangle set.
// ----------------------------------------------------------------------------
interface drs_op_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic [14:0]        rect_w;
	logic [14:0]        rect_h;

	modport source (output valid, cmd, rect_x, rect_y, rect_w, rect_h, input ready);
	modport sink (input valid, cmd, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

interface drs_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_x;
	logic signed [15:0] out_y;
	logic [15:0]        out_w;
	logic [15:0]        out_h;
	logic [5:0]         entry_total;
	logic               overflow_seen;
	logic               last;

	modport source (output valid, out_x, out_y, out_w, out_h, entry_total,
		overflow_seen, last, input ready);
	modport sink (input valid, out_x, out_y, out_w, out_h, entry_total,
		overflow_seen, last, output ready);
endinterface

@@ src/drs_ram.sv @@
// ----------------------------------------------------------------------------
// drs_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module drs_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// Write and read; a read of the entry being written returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;
endmodule

@@ src/drs_engine.sv @@
// ----------------------------------------------------------------------------
// drs_engine
// Sequencer that walks the rectangle table and fragment stack memories.
// ----------------------------------------------------------------------------
module drs_engine #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  drs_pkg::cmd_t      cmd,
	input  drs_pkg::box_t      opnd,
	input  logic               res_free,
	output drs_pkg::eng_stat_t stat,
	output drs_pkg::res_item_t item
);
	import drs_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = REC_W + CW;

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_RD   = 12'b0000_0000_0010,
		S_EV   = 12'b0000_0000_0100,
		S_EX   = 12'b0000_0000_1000,
		S_DRD  = 12'b0000_0001_0000,
		S_DWR  = 12'b0000_0010_0000,
		S_PUSH = 12'b0000_0100_0000,
		S_FEND = 12'b0000_1000_0000,
		S_POPW = 12'b0001_0000_0000,
		S_WRD  = 12'b0010_0000_0000,
		S_WEV  = 12'b0100_0000_0000,
		S_EMIT = 12'b1000_0000_0000
	} state_t;

	state_t          state_q;
	cmd_t            cmd_q;
	box_t            op_q;
	crd_t            or_q;
	crd_t            ob_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   i_q;
	box_t            n_q;
	logic            cov_q;
	logic [SDW-1:0]  sd_q;
	logic            ovf_q;
	box_t            p_s1;
	crd_t            pr_s1;
	crd_t            pb_s1;
	crd_t            nr_s1;
	crd_t            nb_s1;
	logic [3:0]      pf_q;
	crd_t            ux1_q;
	crd_t            uy1_q;
	crd_t            ux2_q;
	crd_t            uy2_q;
	res_item_t       res_q;

	logic            tbl_we;
	logic [IW-1:0]   tbl_waddr;
	rec_t            tbl_wdata;
	logic [IW-1:0]   tbl_raddr;
	rec_t            tbl_rdata;
	logic            stk_we;
	logic [FAW-1:0]  stk_waddr;
	logic [SW-1:0]   stk_wdata;
	logic [FAW-1:0]  stk_raddr;
	logic [SW-1:0]   stk_rdata;

	add_res_t        ar;
	box_t            pm;
	logic            tbl_full;
	logic            stk_full;
	logic [CW-1:0]   i_inc;
	logic [CW-1:0]   cnt_dec;
	logic [SDW-1:0]  sd_dec;
	logic [3:0]      sub_flags;
	logic            sub_hit;
	crd_t            my;
	crd_t            mh;
	box_t            piece;
	crd_t            cx0;
	crd_t            cy0;
	crd_t            cx1;
	crd_t            cy1;
	logic            clip_keep;
	box_t            clip_box;
	logic            op_empty;

	drs_ram #(.DEPTH(CAPACITY), .WIDTH(REC_W)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	drs_ram #(.DEPTH(FRAG_DEPTH), .WIDTH(SW)) u_stk (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Shared decode
	assign tbl_full = (cnt_q == CW'(CAPACITY));
	assign stk_full = (sd_q == SDW'(FRAG_DEPTH));
	assign i_inc    = i_q + 1'b1;
	assign cnt_dec  = cnt_q - 1'b1;
	assign sd_dec   = sd_q - 1'b1;
	assign pm       = rec2box(tbl_rdata);
	assign op_empty = (opnd.w == '0) || (opnd.h == '0);
	assign ar       = add_eval(n_q, nr_s1, nb_s1, p_s1, pr_s1, pb_s1);

	// Subtract: leftover pieces around the removed area
	assign sub_hit   = (pr_s1 > op_q.x) && (pb_s1 > op_q.y) && (p_s1.x < or_q)
		&& (p_s1.y < ob_q);
	assign sub_flags = {pb_s1 > ob_q, pr_s1 > or_q, p_s1.x < op_q.x, p_s1.y < op_q.y};
	assign my        = crd_max(p_s1.y, op_q.y);
	assign mh        = crd_min(pb_s1, ob_q) - my;

	always_comb begin
		piece = p_s1;
		if (pf_q[0]) begin
			piece.h = op_q.y - p_s1.y;
		end else if (pf_q[1]) begin
			piece.y = my;
			piece.w = op_q.x - p_s1.x;
			piece.h = mh;
		end else if (pf_q[2]) begin
			piece.x = or_q;
			piece.y = my;
			piece.w = pr_s1 - or_q;
			piece.h = mh;
		end else begin
			piece.y = ob_q;
			piece.h = pb_s1 - ob_q;
		end
	end

	// Clip: intersection with the operand
	assign cx0       = crd_max(p_s1.x, op_q.x);
	assign cy0       = crd_max(p_s1.y, op_q.y);
	assign cx1       = crd_min(pr_s1, or_q);
	assign cy1       = crd_min(pb_s1, ob_q);
	assign clip_keep = (cx1 > cx0) && (cy1 > cy0);
	assign clip_box  = '{x: cx0, y: cy0, w: cx1 - cx0, h: cy1 - cy0};

	// Memory port control
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = i_q[IW-1:0];
		tbl_wdata = box2rec(ar.p_new);
		tbl_raddr = i_q[IW-1:0];
		stk_we    = 1'b0;
		stk_waddr = sd_q[FAW-1:0];
		stk_wdata = {box2rec(ar.n_mod), i_inc};
		stk_raddr = sd_dec[FAW-1:0];
		case (state_q)
			S_EX: begin
				case (cmd_q)
					CMD_ADD: begin
						tbl_we = (ar.act == ACT_TRIM);
						stk_we = (ar.act == ACT_ADV) && ar.split && !stk_full;
					end
					CMD_CLIP: begin
						tbl_we    = clip_keep;
						tbl_wdata = box2rec(clip_box);
					end
					default: begin
					end
				endcase
			end
			S_DRD: begin
				tbl_raddr = cnt_dec[IW-1:0];
			end
			S_DWR: begin
				tbl_we    = 1'b1;
				tbl_wdata = tbl_rdata;
			end
			S_PUSH: begin
				tbl_we    = !tbl_full;
				tbl_waddr = cnt_q[IW-1:0];
				tbl_wdata = box2rec(piece);
			end
			S_FEND: begin
				tbl_we    = !cov_q && !tbl_full;
				tbl_waddr = cnt_q[IW-1:0];
				tbl_wdata = box2rec(n_q);
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= CMD_ADD;
			op_q    <= '0;
			or_q    <= '0;
			ob_q    <= '0;
			cnt_q   <= '0;
			i_q     <= '0;
			n_q     <= '0;
			cov_q   <= 1'b0;
			sd_q    <= '0;
			ovf_q   <= 1'b0;
			p_s1    <= '0;
			pr_s1   <= '0;
			pb_s1   <= '0;
			nr_s1   <= '0;
			nb_s1   <= '0;
			pf_q    <= '0;
			ux1_q   <= '0;
			uy1_q   <= '0;
			ux2_q   <= '0;
			uy2_q   <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						op_q  <= opnd;
						or_q  <= opnd.x + opnd.w;
						ob_q  <= opnd.y + opnd.h;
						n_q   <= opnd;
						i_q   <= '0;
						cov_q <= 1'b0;
						sd_q  <= '0;
						case (cmd)
							CMD_DUMP: state_q <= S_WRD;
							CMD_CLIP: state_q <= S_RD;
							default:  state_q <= op_empty ? S_WRD : S_RD;
						endcase
					end
				end
				S_RD: begin
					if (i_q < cnt_q) begin
						state_q <= S_EV;
					end else if (cmd_q == CMD_ADD) begin
						state_q <= S_FEND;
					end else begin
						i_q     <= '0;
						state_q <= S_WRD;
					end
				end
				S_EV: begin
					// Register the entry and all edges
					p_s1    <= pm;
					pr_s1   <= pm.x + pm.w;
					pb_s1   <= pm.y + pm.h;
					nr_s1   <= n_q.x + n_q.w;
					nb_s1   <= n_q.y + n_q.h;
					state_q <= S_EX;
				end
				S_EX: begin
					case (cmd_q)
						CMD_ADD: begin
							case (ar.act)
								ACT_SKIP, ACT_TRIM: begin
									i_q     <= i_inc;
									state_q <= S_RD;
								end
								ACT_COVER: begin
									cov_q   <= 1'b1;
									state_q <= S_FEND;
								end
								ACT_DEL: begin
									state_q <= S_DRD;
								end
								default: begin
									if (ar.split) begin
										if (stk_full) begin
											ovf_q <= 1'b1;
											n_q   <= ar.n_mod;
										end else begin
											sd_q <= sd_q + 1'b1;
											n_q  <= ar.xr;
										end
									end else if (ar.keep) begin
										n_q <= ar.n_mod;
									end else begin
										n_q <= ar.xr;
									end
									i_q     <= i_inc;
									state_q <= S_RD;
								end
							endcase
						end
						CMD_SUB: begin
							if (!sub_hit) begin
								i_q     <= i_inc;
								state_q <= S_RD;
							end else begin
								pf_q    <= sub_flags;
								state_q <= (sub_flags != '0) ? S_PUSH : S_DRD;
							end
						end
						default: begin
							if (clip_keep) begin
								i_q     <= i_inc;
								state_q <= S_RD;
							end else begin
								state_q <= S_DRD;
							end
						end
					endcase
				end
				S_DRD: begin
					// Move the last entry into the hole
					cnt_q   <= cnt_dec;
					state_q <= S_DWR;
				end
				S_DWR: begin
					state_q <= S_RD;
				end
				S_PUSH: begin
					if (tbl_full) begin
						ovf_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
					pf_q <= pf_q & (pf_q - 1'b1);
					if ((pf_q & (pf_q - 1'b1)) == '0) begin
						state_q <= S_DRD;
					end
				end
				S_FEND: begin
					if (!cov_q) begin
						if (tbl_full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (sd_q == '0) begin
						i_q     <= '0;
						state_q <= S_WRD;
					end else begin
						sd_q    <= sd_dec;
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					n_q     <= rec2box(stk_rdata[SW-1:CW]);
					i_q     <= stk_rdata[CW-1:0];
					cov_q   <= 1'b0;
					state_q <= S_RD;
				end
				S_WRD: begin
					if (i_q < cnt_q) begin
						state_q <= S_WEV;
					end else if (cmd_q == CMD_DUMP) begin
						state_q <= S_IDLE;
					end else begin
						res_q.total <= 6'(cnt_q);
						res_q.ovf   <= ovf_q;
						res_q.last  <= 1'b1;
						if (cnt_q == '0) begin
							res_q.rec <= '0;
						end else begin
							res_q.rec <= box2rec('{x: ux1_q, y: uy1_q,
								w: ux2_q - ux1_q, h: uy2_q - uy1_q});
						end
						state_q <= S_EMIT;
					end
				end
				S_WEV: begin
					if (cmd_q == CMD_DUMP) begin
						res_q.rec   <= tbl_rdata;
						res_q.total <= 6'(cnt_q);
						res_q.ovf   <= ovf_q;
						res_q.last  <= (i_inc == cnt_q);
						state_q     <= S_EMIT;
					end else begin
						// Grow the union box
						if (i_q == '0) begin
							ux1_q <= pm.x;
							uy1_q <= pm.y;
							ux2_q <= pm.x + pm.w;
							uy2_q <= pm.y + pm.h;
						end else begin
							ux1_q <= crd_min(ux1_q, pm.x);
							uy1_q <= crd_min(uy1_q, pm.y);
							ux2_q <= crd_max(ux2_q, pm.x + pm.w);
							uy2_q <= crd_max(uy2_q, pm.y + pm.h);
						end
						i_q     <= i_inc;
						state_q <= S_WRD;
					end
				end
				S_EMIT: begin
					if (res_free) begin
						if (cmd_q == CMD_DUMP) begin
							i_q     <= i_inc;
							state_q <= S_WRD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == S_IDLE);
	assign stat.load = (state_q == S_EMIT) && res_free;
	assign item      = res_q;
endmodule

@@ src/dirty_rectangle_set.sv @@
// ----------------------------------------------------------------------------
// dirty_rectangle_set
// Bounded table of non-overlapping rectangles with add, subtract, clip, dump.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | handshake
//  op      | in  | cmd, rect_x, rect_y, rect_w, rect_h              | valid/ready
//  res     | out | out_x/y/w/h, entry_total, overflow_seen, last    | valid/ready
//
//  Each table walk reads each stored entry in turn, registers its edges and
//  decides; a deletion adds a read and a move of the last entry into the
//  hole, and each new piece a push into the table. An add also pushes each
//  fragment into the table and pops the stack. Then a union walk over the
//  entries gives the result, or a dump emits each entry. Each popped add
//  fragment restarts its walk from its saved index.
//  Reset empties the table at once; no clearing pass.
//  A result stalls in the engine while the result register holds an untaken
//  item; the register takes a new item as the last result is taken.
// ----------------------------------------------------------------------------
module dirty_rectangle_set #(
	parameter int CAPACITY = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	drs_op_if.sink         op,
	drs_res_if.source      res
);
	import drs_pkg::*;

	box_t      opnd;
	crd_t      ex;
	crd_t      ey;
	eng_stat_t stat;
	res_item_t item;
	res_item_t out_q;
	logic      out_vld_q;
	logic      res_free;

	// Saturate the right and bottom edges of the operand
	always_comb begin
		opnd.x = {{2{op.rect_x[15]}}, op.rect_x};
		opnd.y = {{2{op.rect_y[15]}}, op.rect_y};
		ex     = opnd.x + signed'({3'b000, op.rect_w});
		ey     = opnd.y + signed'({3'b000, op.rect_h});
		if (ex > MAX_EDGE) begin
			ex = MAX_EDGE;
		end
		if (ey > MAX_EDGE) begin
			ey = MAX_EDGE;
		end
		opnd.w = ex - opnd.x;
		opnd.h = ey - opnd.y;
	end

	assign op.ready = stat.idle;
	assign res_free = !out_vld_q || res.ready;

	drs_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (op.valid && op.ready),
		.cmd      (cmd_t'(op.cmd)),
		.opnd     (opnd),
		.res_free (res_free),
		.stat     (stat),
		.item     (item)
	);

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (stat.load) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.load) begin
			out_q <= item;
		end
	end

	assign res.valid         = out_vld_q;
	assign res.out_x         = out_q.rec.x;
	assign res.out_y         = out_q.rec.y;
	assign res.out_w         = out_q.rec.w;
	assign res.out_h         = out_q.rec.h;
	assign res.entry_total   = out_q.total;
	assign res.overflow_seen = out_q.ovf;
	assign res.last          = out_q.last;
endmodule

@@ src/drs_check.sv @@
// ----------------------------------------------------------------------------
// drs_check
// Port-level checks on the result stream of the dirty rectangle set.
// ----------------------------------------------------------------------------
module drs_check #(
	parameter int CAPACITY = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [15:0] out_x,
	input logic [15:0] out_y,
	input logic [15:0] out_w,
	input logic [15:0] out_h,
	input logic [5:0]  entry_total,
	input logic        overflow_seen,
	input logic        last
);
	`include "assert_macros.svh"

	logic [71:0] pay;
	logic        seen_q;
	logic        more_q;
	logic [5:0]  tot_q;
	logic        total_ok;
	logic        box_zero;

	assign pay      = {out_x, out_y, out_w, out_h, entry_total, overflow_seen, last};
	assign total_ok = (7'(entry_total) <= 7'(CAPACITY));
	assign box_zero = (out_x == '0) && (out_y == '0) && (out_w == '0) && (out_h == '0);

	// Track the overflow flag and the open dump stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			more_q <= 1'b0;
			tot_q  <= '0;
		end else if (res_valid && res_ready) begin
			seen_q <= seen_q | overflow_seen;
			more_q <= !last;
			tot_q  <= entry_total;
		end
	end

	`DRS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(pay))
	`DRS_ASSERT_NOW(a_total_cap, clk, arst_n, res_valid, total_ok)
	`DRS_ASSERT_NOW(a_ovf_sticky, clk, arst_n, res_valid && seen_q, overflow_seen)
	`DRS_ASSERT_NOW(a_empty_box, clk, arst_n, res_valid && entry_total == 6'd0 && CAPACITY < 64, box_zero)
	`DRS_ASSERT_NOW(a_dump_total, clk, arst_n, res_valid && more_q, entry_total == tot_q)
endmodule

bind dirty_rectangle_set drs_check #(.CAPACITY(CAPACITY)) u_drs_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.out_x         (res.out_x),
	.out_y         (res.out_y),
	.out_w         (res.out_w),
	.out_h         (res.out_h),
	.entry_total   (res.entry_total),
	.overflow_seen (res.overflow_seen),
	.last          (res.last)
);
